[sv/resonant_four_pole_lowpass_top_assert.svh]
// Assertion macros used by the filter top level
`ifndef RESONANT_FOUR_POLE_LOWPASS_TOP_ASSERT_SVH
`define RESONANT_FOUR_POLE_LOWPASS_TOP_ASSERT_SVH

// clocked check, masked while reset is asserted
`define RFPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define RFPL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/rfpl_pkg.sv]
// Package: widths, constants, codes and helpers of the ladder filter
package rfpl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int POLE_COUNT  = 4;
  localparam int POLE_IDX_W  = $clog2(POLE_COUNT);
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int COEF_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // multiplier operands: A carries samples and differences, B carries coefficients
  localparam int MUL_A_W = SAMPLE_BITS + 1;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = SAMPLE_BITS + 4;

  localparam int LIM = (99 * (1 << (SAMPLE_BITS - 1)) + 50) / 100;
  localparam logic signed [MUL_B_W-1:0] IN_GAIN = 17'sd45875;

  localparam logic signed [COEF_W-1:0] COEF_RESET = -16'sd14557;
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd2944;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_IN,
    OP_ADD_IN,
    OP_MUL_POLE,
    OP_ADD_POLE,
    OP_MUL_FB,
    OP_ADD_FB,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_IN,
    ST_ADD_IN,
    ST_MUL_POLE,
    ST_ADD_POLE,
    ST_MUL_FB,
    ST_ADD_FB,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [POLE_IDX_W-1:0] pole_idx;
  } cmd_t;

  // clamp a wide intermediate to +-LIM
  function automatic logic signed [SAMPLE_BITS-1:0] sat_f(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] lim_w;
    logic signed [WIDE_W-1:0] r;
    lim_w = WIDE_W'(LIM);
    if (v > lim_w) begin
      r = lim_w;
    end else if (v < -lim_w) begin
      r = -lim_w;
    end else begin
      r = v;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

[sv/rfpl_ctrl.sv]
// Controller: sequences input scaling, the four poles, feedback and output
module rfpl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output rfpl_pkg::cmd_t cmd_o
);
  import rfpl_pkg::*;

  state_e                state_q, state_d;
  logic [POLE_IDX_W-1:0] pole_q, pole_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pole_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pole_q      <= pole_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    pole_d       = pole_q;
    out_valid_d  = out_valid_q;
    cmd_o.op     = OP_NONE;
    cmd_o.pole_idx = pole_q;
    s_tready_o   = 1'b0;

    // drop the word once the sink takes it
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL_IN;
        end
      end
      ST_MUL_IN: begin
        cmd_o.op = OP_MUL_IN;
        state_d  = ST_ADD_IN;
      end
      ST_ADD_IN: begin
        cmd_o.op = OP_ADD_IN;
        pole_d   = '0;
        state_d  = ST_MUL_POLE;
      end
      ST_MUL_POLE: begin
        cmd_o.op = OP_MUL_POLE;
        state_d  = ST_ADD_POLE;
      end
      ST_ADD_POLE: begin
        cmd_o.op = OP_ADD_POLE;
        if (pole_q == POLE_IDX_W'(POLE_COUNT - 1)) begin
          state_d = ST_MUL_FB;
        end else begin
          pole_d  = pole_q + 1'b1;
          state_d = ST_MUL_POLE;
        end
      end
      ST_MUL_FB: begin
        cmd_o.op = OP_MUL_FB;
        state_d  = ST_ADD_FB;
      end
      ST_ADD_FB: begin
        cmd_o.op = OP_ADD_FB;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output slot is free
        if (!out_valid_q || m_tready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_o = out_valid_q;

endmodule

[sv/rfpl_datapath.sv]
// Datapath: shared multiplier, pole states, feedback term and config registers
module rfpl_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rfpl_pkg::cmd_t                   cmd_i,
  input  logic [rfpl_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                             cfg_we_i,
  input  logic [rfpl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rfpl_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic [rfpl_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import rfpl_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF14 = PROD_W'(1) <<< 13;
  localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(1) <<< 14;
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) <<< 15;
  localparam logic signed [WIDE_W-1:0] HALF2  = WIDE_W'(2);

  logic signed [COEF_W-1:0]      coef_q;
  logic        [GAIN_W-1:0]      gain_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] v_q;
  logic signed [SAMPLE_BITS-1:0] fb_q;
  logic signed [SAMPLE_BITS-1:0] pole_q [POLE_COUNT];
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic signed [PROD_W-1:0]      prod_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SAMPLE_BITS-1:0] t_sel;
  logic signed [PROD_W-1:0]  sh16, sh14, sh15;
  logic signed [WIDE_W-1:0]  a_w, diff_w, v_in_w, pole_sum_w, s_w, fb_w;
  logic signed [SAMPLE_BITS-1:0] s_sat;

  // config registers: the user must make writes only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CUTOFF: coef_q <= cfg_wdata_i[COEF_W-1:0];
        REG_GAIN:   gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  assign t_sel = pole_q[cmd_i.pole_idx];

  always_comb begin
    case (cmd_i.op)
      OP_MUL_POLE: begin
        mul_a = MUL_A_W'(v_q) - MUL_A_W'(t_sel);
        mul_b = MUL_B_W'(coef_q);
      end
      OP_MUL_FB: begin
        mul_a = MUL_A_W'(v_q);
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = IN_GAIN;
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // rounding shifts of the registered product, ties toward +infinity
  always_comb begin
    sh16       = (prod_q + HALF16) >>> 16;
    sh14       = (prod_q + HALF14) >>> 14;
    sh15       = (prod_q + HALF15) >>> 15;
    a_w        = sh16[WIDE_W-1:0];
    diff_w     = a_w - WIDE_W'(fb_q);
    v_in_w     = (diff_w + HALF2) >>> 2;
    s_w        = WIDE_W'(v_q) + sh14[WIDE_W-1:0];
    s_sat      = sat_f(s_w);
    pole_sum_w = WIDE_W'(s_sat) + WIDE_W'(t_sel);
    fb_w       = sh15[WIDE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= '0;
      for (int k = 0; k < POLE_COUNT; k++) begin
        pole_q[k] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_ADD_POLE: pole_q[cmd_i.pole_idx] <= s_sat;
        OP_ADD_FB:   fb_q <= sat_f(fb_w);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD:     x_q    <= sample_in_i;
      OP_MUL_IN,
      OP_MUL_POLE,
      OP_MUL_FB:   prod_q <= prod_d;
      OP_ADD_IN:   v_q    <= v_in_w[SAMPLE_BITS-1:0];
      OP_ADD_POLE: v_q    <= sat_f(pole_sum_w);
      OP_OUT:      out_q  <= v_q;
      default:     ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

[sv/resonant_four_pole_lowpass_top.sv]
// Resonant four-pole ladder low-pass filter, top level.
// One multiplier is shared by input scaling, the four poles and the feedback
// product, each a multiply step followed by an add step.
// No new word is accepted until the current result is written to the output register.
// Reset: pole states and feedback term clear, cutoff -14557, gain 2944,
// output empty; no clearing pass.
`include "resonant_four_pole_lowpass_top_assert.svh"

module resonant_four_pole_lowpass_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [rfpl_pkg::DATA_W-1:0]  s_tdata_i,   // [SAMPLE_BITS-1:0] sample_in
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [rfpl_pkg::DATA_W-1:0]  m_tdata_o,   // [SAMPLE_BITS-1:0] sample_out
  input  logic                         cfg_we_i,
  input  logic [rfpl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rfpl_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import rfpl_pkg::*;

  cmd_t                   cmd;
  logic [SAMPLE_BITS-1:0] sample_out;

  rfpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd)
  );

  rfpl_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (s_tdata_i[SAMPLE_BITS-1:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_out_o (sample_out)
  );

  assign m_tdata_o = DATA_W'(sample_out);

  `RFPL_ASSERT(a_busy_after_accept, (s_tvalid_i && s_tready_o) |=> !s_tready_o, "accepted a word while busy")
  `RFPL_ASSERT(a_out_slot_free, (cmd.op == OP_OUT) |-> (!m_tvalid_o || m_tready_i), "output word overwritten")
  `RFPL_ASSERT(a_out_in_range, m_tvalid_o |-> (($signed(m_tdata_o[SAMPLE_BITS-1:0]) <= LIM) && ($signed(m_tdata_o[SAMPLE_BITS-1:0]) >= -LIM)), "output beyond clamp limit")
  `RFPL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_tvalid_o || rst_ni, "output valid out of reset")

endmodule
